>>> hw/rtl/fmpf_pkg.sv
// Package for the first-match packet filter: operation and status codes,
// item and entry structs, and the control structs between the units.
// No dependencies.
package fmpf_pkg;

   localparam int ADDR_WIDTH      = 32;
   localparam int SLOT_WIDTH      = 4;
   localparam int OUT_COUNT_WIDTH = 32;

   localparam logic [2:0] OP_CLASSIFY       = 3'd0;
   localparam logic [2:0] OP_ADD_RULE       = 3'd1;
   localparam logic [2:0] OP_ADD_MONITOR    = 3'd2;
   localparam logic [2:0] OP_REMOVE_MONITOR = 3'd3;
   localparam logic [2:0] OP_READ_MONITOR   = 3'd4;

   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   localparam logic DIR_INCOMING = 1'b0;

   typedef enum logic [1:0] {
      MON_COUNT,
      MON_ADD,
      MON_REMOVE,
      MON_READ
   } mon_op_type;

   typedef struct packed {
      logic [2:0]            operation;
      logic                  direction;
      logic [ADDR_WIDTH-1:0] source_address;
      logic [ADDR_WIDTH-1:0] destination_address;
      logic                  source_given;
      logic                  destination_given;
      logic                  rule_accepts;
      logic [SLOT_WIDTH-1:0] slot;
   } req_item_type;

   typedef struct packed {
      logic                       verdict;
      logic [1:0]                 status;
      logic [ADDR_WIDTH-1:0]      monitor_address;
      logic [OUT_COUNT_WIDTH-1:0] received_count;
      logic [OUT_COUNT_WIDTH-1:0] dropped_count;
   } rsp_item_type;

   typedef struct packed {
      logic [ADDR_WIDTH-1:0] source_address;
      logic [ADDR_WIDTH-1:0] destination_address;
      logic                  direction;
      logic                  source_given;
      logic                  destination_given;
      logic                  accepts;
   } rule_entry_type;

   typedef struct packed {
      logic           classify;
      logic           add;
      rule_entry_type entry;
   } rule_cmd_type;

   typedef struct packed {
      logic done;
      logic verdict;
      logic full;
   } rule_result_type;

   typedef struct packed {
      logic                  start;
      mon_op_type            op;
      logic [ADDR_WIDTH-1:0] address;
      logic                  accepted;
      logic [SLOT_WIDTH-1:0] slot;
   } mon_cmd_type;

   typedef struct packed {
      logic                       done;
      logic [1:0]                 status;
      logic [ADDR_WIDTH-1:0]      address;
      logic [OUT_COUNT_WIDTH-1:0] received;
      logic [OUT_COUNT_WIDTH-1:0] dropped;
   } mon_result_type;

endpackage

>>> hw/rtl/fmpf_if.sv
// Valid/ready channel interfaces of the packet filter: request and response.
// Depends on fmpf_pkg.
interface fmpf_req_if;
   import fmpf_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [2:0]            operation;
   logic                  direction;
   logic [ADDR_WIDTH-1:0] source_address;
   logic [ADDR_WIDTH-1:0] destination_address;
   logic                  source_given;
   logic                  destination_given;
   logic                  rule_accepts;
   logic [SLOT_WIDTH-1:0] slot;

   modport source (
      output valid, operation, direction, source_address, destination_address,
             source_given, destination_given, rule_accepts, slot,
      input  ready
   );
   modport sink (
      input  valid, operation, direction, source_address, destination_address,
             source_given, destination_given, rule_accepts, slot,
      output ready
   );
endinterface

interface fmpf_rsp_if;
   import fmpf_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       verdict;
   logic [1:0]                 status;
   logic [ADDR_WIDTH-1:0]      monitor_address;
   logic [OUT_COUNT_WIDTH-1:0] received_count;
   logic [OUT_COUNT_WIDTH-1:0] dropped_count;

   modport source (
      output valid, verdict, status, monitor_address, received_count, dropped_count,
      input  ready
   );
   modport sink (
      input  valid, verdict, status, monitor_address, received_count, dropped_count,
      output ready
   );
endinterface

>>> hw/rtl/fmpf_rule_table.sv
// Rule table: rule memory, fill count and the newest-first match scan.
// Depends on fmpf_pkg.
module fmpf_rule_table #(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  fmpf_pkg::rule_cmd_type    cmd,
   output fmpf_pkg::rule_result_type result
);
   import fmpf_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   typedef enum logic {ST_IDLE, ST_SCAN} state_type;

   state_type       state_ff;
   logic [CNT_W-1:0] count_ff;
   logic [IDX_W-1:0] ptr_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic            issue_ff;
   rule_entry_type  key_ff;
   rule_result_type result_ff;

   rule_entry_type  mem [DEPTH];
   rule_entry_type  rd_q;

   logic hit;
   logic last;
   logic rd_en;
   logic wr_en;

   always_comb begin
      hit = issue_ff && (rd_q.direction == key_ff.direction)
         && (!rd_q.source_given || (rd_q.source_address == key_ff.source_address))
         && (!rd_q.destination_given
             || (rd_q.destination_address == key_ff.destination_address));
      last  = issue_ff && (rd_idx_ff == '0);
      rd_en = (state_ff == ST_SCAN) && !hit && !last;
      wr_en = (state_ff == ST_IDLE) && cmd.add && (count_ff != FULL_COUNT);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[IDX_W-1:0]] <= cmd.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q <= mem[ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         issue_ff  <= 1'b0;
         result_ff <= '0;
      end else begin
         result_ff.done <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               issue_ff <= 1'b0;
               if (cmd.classify) begin
                  key_ff <= cmd.entry;
                  ptr_ff <= IDX_W'(count_ff - 1'b1);
                  if (count_ff == '0) begin
                     result_ff.done    <= 1'b1;
                     result_ff.verdict <= 1'b1;
                  end else begin
                     state_ff <= ST_SCAN;
                  end
               end else if (cmd.add) begin
                  result_ff.done    <= 1'b1;
                  result_ff.verdict <= 1'b0;
                  result_ff.full    <= (count_ff == FULL_COUNT);
                  if (count_ff != FULL_COUNT) begin
                     count_ff <= count_ff + 1'b1;
                  end
               end
            end
            ST_SCAN: begin
               if (hit) begin
                  result_ff.done    <= 1'b1;
                  result_ff.verdict <= rd_q.accepts;
                  state_ff          <= ST_IDLE;
               end else if (last) begin
                  result_ff.done    <= 1'b1;
                  result_ff.verdict <= 1'b1;
                  state_ff          <= ST_IDLE;
               end else begin
                  issue_ff  <= 1'b1;
                  rd_idx_ff <= ptr_ff;
                  ptr_ff    <= ptr_ff - 1'b1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign result = result_ff;

   assert property (@(posedge clock) disable iff (reset) count_ff <= FULL_COUNT)
      else $error("rule count beyond table depth");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (count_ff != '0))
      else $error("rule scan running on an empty table");

endmodule

>>> hw/rtl/fmpf_monitor_table.sv
// Monitor table: watched addresses with saturating counters in one memory,
// newest-first lookup, counter update, insert, compacting removal and reads.
// Depends on fmpf_pkg.
module fmpf_monitor_table #(
   parameter int DEPTH         = 16,
   parameter int COUNTER_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  fmpf_pkg::mon_cmd_type    cmd,
   output fmpf_pkg::mon_result_type result
);
   import fmpf_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > SLOT_WIDTH) ? CNT_W : SLOT_WIDTH;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   typedef struct packed {
      logic [ADDR_WIDTH-1:0]    address;
      logic [COUNTER_WIDTH-1:0] received;
      logic [COUNTER_WIDTH-1:0] dropped;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_SHIFT_READ,
      ST_SHIFT_WRITE,
      ST_READ_OUT
   } state_type;

   state_type             state_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [IDX_W-1:0]      ptr_ff;
   logic [IDX_W-1:0]      rd_idx_ff;
   logic                  issue_ff;
   mon_op_type            op_ff;
   logic [ADDR_WIDTH-1:0] key_ff;
   logic                  accepted_ff;
   mon_result_type        result_ff;

   entry_type             mem [DEPTH];
   entry_type             rd_q;

   logic             hit;
   logic             last;
   logic             scan_issue;
   logic             read_miss;
   logic [IDX_W-1:0] read_idx;
   logic [CNT_W-1:0] shift_next;
   logic             shift_end;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   entry_type        bumped;

   function automatic logic [COUNTER_WIDTH-1:0] sat_inc(input logic [COUNTER_WIDTH-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic logic [OUT_COUNT_WIDTH-1:0] clip(input logic [COUNTER_WIDTH-1:0] v);
      logic [COUNTER_WIDTH+OUT_COUNT_WIDTH-1:0] wide;
      wide = {{OUT_COUNT_WIDTH{1'b0}}, v};
      if (wide > {{COUNTER_WIDTH{1'b0}}, {OUT_COUNT_WIDTH{1'b1}}}) begin
         return '1;
      end
      return wide[OUT_COUNT_WIDTH-1:0];
   endfunction

   always_comb begin
      hit        = issue_ff && (rd_q.address == key_ff);
      last       = issue_ff && (rd_idx_ff == '0);
      scan_issue = !hit && !last;
      read_miss  = (CMP_W'(cmd.slot) >= CMP_W'(count_ff));
      read_idx   = IDX_W'(CMP_W'(count_ff) - CMP_W'(cmd.slot) - 1'b1);
      shift_next = CNT_W'(ptr_ff) + 1'b1;
      shift_end  = (shift_next >= count_ff);

      bumped = rd_q;
      if (accepted_ff) begin
         bumped.received = sat_inc(rd_q.received);
      end else begin
         bumped.dropped = sat_inc(rd_q.dropped);
      end

      rd_en   = 1'b0;
      rd_addr = ptr_ff;
      wr_en   = 1'b0;
      wr_addr = count_ff[IDX_W-1:0];
      wr_data = '{address: cmd.address, received: '0, dropped: '0};
      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = read_idx;
            rd_en   = cmd.start && (cmd.op == MON_READ) && !read_miss;
            wr_en   = cmd.start && (cmd.op == MON_ADD) && (count_ff != FULL_COUNT);
         end
         ST_SCAN: begin
            rd_en = scan_issue;
         end
         ST_UPDATE: begin
            wr_en   = 1'b1;
            wr_addr = rd_idx_ff;
            wr_data = bumped;
         end
         ST_SHIFT_READ: begin
            rd_en   = !shift_end;
            rd_addr = shift_next[IDX_W-1:0];
         end
         ST_SHIFT_WRITE: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = rd_q;
         end
         ST_READ_OUT: begin
            rd_en = 1'b0;
         end
         default: rd_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         issue_ff  <= 1'b0;
         result_ff <= '0;
      end else begin
         result_ff.done <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               issue_ff <= 1'b0;
               if (cmd.start) begin
                  op_ff       <= cmd.op;
                  key_ff      <= cmd.address;
                  accepted_ff <= cmd.accepted;
                  ptr_ff      <= IDX_W'(count_ff - 1'b1);
                  result_ff   <= '0;
                  unique case (cmd.op)
                     MON_COUNT, MON_REMOVE: begin
                        if (count_ff == '0) begin
                           result_ff.done   <= 1'b1;
                           result_ff.status <= (cmd.op == MON_COUNT) ? STATUS_DONE
                                                                     : STATUS_NOT_FOUND;
                        end else begin
                           state_ff <= ST_SCAN;
                        end
                     end
                     MON_ADD: begin
                        result_ff.done <= 1'b1;
                        if (count_ff == FULL_COUNT) begin
                           result_ff.status <= STATUS_FULL;
                        end else begin
                           count_ff <= count_ff + 1'b1;
                        end
                     end
                     MON_READ: begin
                        if (read_miss) begin
                           result_ff.done   <= 1'b1;
                           result_ff.status <= STATUS_NOT_FOUND;
                        end else begin
                           state_ff <= ST_READ_OUT;
                        end
                     end
                     default: state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_SCAN: begin
               if (hit) begin
                  ptr_ff   <= rd_idx_ff;
                  state_ff <= (op_ff == MON_COUNT) ? ST_UPDATE : ST_SHIFT_READ;
               end else if (last) begin
                  result_ff.done   <= 1'b1;
                  result_ff.status <= (op_ff == MON_COUNT) ? STATUS_DONE : STATUS_NOT_FOUND;
                  state_ff         <= ST_IDLE;
               end else begin
                  issue_ff  <= 1'b1;
                  rd_idx_ff <= ptr_ff;
                  ptr_ff    <= ptr_ff - 1'b1;
               end
            end
            ST_UPDATE: begin
               result_ff.done   <= 1'b1;
               result_ff.status <= STATUS_DONE;
               state_ff         <= ST_IDLE;
            end
            ST_SHIFT_READ: begin
               if (shift_end) begin
                  count_ff         <= count_ff - 1'b1;
                  result_ff.done   <= 1'b1;
                  result_ff.status <= STATUS_DONE;
                  state_ff         <= ST_IDLE;
               end else begin
                  state_ff <= ST_SHIFT_WRITE;
               end
            end
            ST_SHIFT_WRITE: begin
               ptr_ff   <= ptr_ff + 1'b1;
               state_ff <= ST_SHIFT_READ;
            end
            ST_READ_OUT: begin
               result_ff.done     <= 1'b1;
               result_ff.status   <= STATUS_DONE;
               result_ff.address  <= rd_q.address;
               result_ff.received <= clip(rd_q.received);
               result_ff.dropped  <= clip(rd_q.dropped);
               state_ff           <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign result = result_ff;

   assert property (@(posedge clock) disable iff (reset) count_ff <= FULL_COUNT)
      else $error("monitor count beyond table depth");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT_WRITE) |-> (CNT_W'(ptr_ff) + 1'b1 < count_ff))
      else $error("compaction writes past the last stored entry");

endmodule

>>> hw/rtl/first_match_packet_filter.sv
// Top level of the first-match packet filter: request/response channels,
// operation sequencing and the response register.
// Depends on fmpf_pkg, fmpf_if, fmpf_rule_table and fmpf_monitor_table.
//
//   channel   direction  transfer moves
//   req_ch    in         one operation: classify, add rule, add/remove/read monitor
//   rsp_ch    out        one result: verdict, status, monitor address and counters
//
// One request is in flight at a time; req_ch.ready is high while the sequencer
// is idle, also while a finished response still waits in the output register.
// An outgoing classify reads the rule memory once per stored rule, newest
// first, until the first match. An incoming packet also reads the watched
// entries, newest first, up to one read per entry, and writes back the counter
// of a matching one. Removing a monitor moves each later entry down to close
// the gap, with one read and one write per entry moved. Reset is synchronous
// and empties both tables at once; a stalled response simply holds the
// sequencer in DONE.
module first_match_packet_filter #(
   parameter int RULE_DEPTH    = 16,
   parameter int MONITOR_DEPTH = 16,
   parameter int COUNTER_WIDTH = 32
) (
   input logic       clock,
   input logic       reset,
   fmpf_req_if.sink   req_ch,
   fmpf_rsp_if.source rsp_ch
);
   import fmpf_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_RULES, ST_MONITOR, ST_DONE} state_type;

   state_type       state_ff;
   req_item_type    item_ff;
   rsp_item_type    res_ff;
   rsp_item_type    rsp_ff;
   logic            rsp_valid_ff;

   logic            accept;
   rule_cmd_type    rule_cmd;
   rule_result_type rule_res;
   mon_cmd_type     mon_cmd;
   mon_result_type  mon_res;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   // Issue unit commands straight off the request on the transfer, or off the
   // held item once the rule scan has a verdict for an incoming packet.
   always_comb begin
      rule_cmd                           = '0;
      rule_cmd.entry.source_address      = req_ch.source_address;
      rule_cmd.entry.destination_address = req_ch.destination_address;
      rule_cmd.entry.direction           = req_ch.direction;
      rule_cmd.entry.source_given        = req_ch.source_given;
      rule_cmd.entry.destination_given   = req_ch.destination_given;
      rule_cmd.entry.accepts             = req_ch.rule_accepts;
      rule_cmd.classify = accept && (req_ch.operation == OP_CLASSIFY);
      rule_cmd.add      = accept && (req_ch.operation == OP_ADD_RULE);

      mon_cmd = '0;
      if (state_ff == ST_RULES) begin
         mon_cmd.start    = rule_res.done && (item_ff.operation == OP_CLASSIFY)
                            && (item_ff.direction == DIR_INCOMING);
         mon_cmd.op       = MON_COUNT;
         mon_cmd.address  = item_ff.source_address;
         mon_cmd.accepted = rule_res.verdict;
      end else begin
         mon_cmd.address = req_ch.source_address;
         mon_cmd.slot    = req_ch.slot;
         case (req_ch.operation)
            OP_ADD_MONITOR: begin
               mon_cmd.start = accept;
               mon_cmd.op    = MON_ADD;
            end
            OP_REMOVE_MONITOR: begin
               mon_cmd.start = accept;
               mon_cmd.op    = MON_REMOVE;
            end
            OP_READ_MONITOR: begin
               mon_cmd.start = accept;
               mon_cmd.op    = MON_READ;
            end
            default: mon_cmd.start = 1'b0;
         endcase
      end
   end

   fmpf_rule_table #(
      .DEPTH (RULE_DEPTH)
   ) u_rules (
      .clock  (clock),
      .reset  (reset),
      .cmd    (rule_cmd),
      .result (rule_res)
   );

   fmpf_monitor_table #(
      .DEPTH         (MONITOR_DEPTH),
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_monitors (
      .clock  (clock),
      .reset  (reset),
      .cmd    (mon_cmd),
      .result (mon_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop the response once the sink takes it
         if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  item_ff.operation           <= req_ch.operation;
                  item_ff.direction           <= req_ch.direction;
                  item_ff.source_address      <= req_ch.source_address;
                  item_ff.destination_address <= req_ch.destination_address;
                  item_ff.source_given        <= req_ch.source_given;
                  item_ff.destination_given   <= req_ch.destination_given;
                  item_ff.rule_accepts        <= req_ch.rule_accepts;
                  item_ff.slot                <= req_ch.slot;
                  res_ff                      <= '0;
                  unique case (req_ch.operation) inside
                     OP_CLASSIFY, OP_ADD_RULE: state_ff <= ST_RULES;
                     OP_ADD_MONITOR, OP_REMOVE_MONITOR, OP_READ_MONITOR:
                        state_ff <= ST_MONITOR;
                     default: state_ff <= ST_DONE;  // unused codes answer all zero
                  endcase
               end
            end
            ST_RULES: begin
               if (rule_res.done) begin
                  if (item_ff.operation == OP_CLASSIFY) begin
                     res_ff.verdict <= rule_res.verdict;
                     state_ff <= (item_ff.direction == DIR_INCOMING) ? ST_MONITOR : ST_DONE;
                  end else begin
                     res_ff.status <= rule_res.full ? STATUS_FULL : STATUS_DONE;
                     state_ff      <= ST_DONE;
                  end
               end
            end
            ST_MONITOR: begin
               if (mon_res.done) begin
                  // a packet count only updates the table; the verdict stands
                  if (item_ff.operation != OP_CLASSIFY) begin
                     res_ff.status          <= mon_res.status;
                     res_ff.monitor_address <= mon_res.address;
                     res_ff.received_count  <= mon_res.received;
                     res_ff.dropped_count   <= mon_res.dropped;
                  end
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               // advance into the output register once it is free
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_ff       <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.verdict         = rsp_ff.verdict;
   assign rsp_ch.status          = rsp_ff.status;
   assign rsp_ch.monitor_address = rsp_ff.monitor_address;
   assign rsp_ch.received_count  = rsp_ff.received_count;
   assign rsp_ch.dropped_count   = rsp_ff.dropped_count;

   assert property (@(posedge clock) disable iff (reset) !(rule_res.done && mon_res.done))
      else $error("rule and monitor units finished in the same cycle");
   assert property (@(posedge clock) disable iff (reset)
      rule_res.done |-> (state_ff == ST_RULES))
      else $error("rule unit finished outside the rule phase");
   assert property (@(posedge clock) disable iff (reset)
      mon_res.done |-> (state_ff == ST_MONITOR))
      else $error("monitor unit finished outside the monitor phase");

endmodule
